### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge.
`define DOSP_ASSERT(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// A condition that implies another in the same cycle.
`define DOSP_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// A condition that implies another in the next cycle.
`define DOSP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/dosp_pkg.sv
// ----------------------------------------------------------------------------
// dosp_pkg
// Types, codes and byte classifiers of the display order stream parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dosp_pkg;

	typedef enum logic [4:0] {
		ST_CC1,
		ST_CC2,
		ST_MAIN,
		ST_HDR_LEN,
		ST_HDR_SKIP,
		ST_RA_ROW,
		ST_RA_COL,
		ST_RA_CHAR,
		ST_SBA_ROW,
		ST_SBA_COL,
		ST_SF_FFW0,
		ST_SF_FFW1,
		ST_SF_FCW0,
		ST_SF_FCW1,
		ST_SF_LEN0,
		ST_SF_LEN1
	} parse_state_t;

	// Event kinds.
	localparam logic [2:0] KIND_TEXT     = 3'd0;
	localparam logic [2:0] KIND_RUN_END  = 3'd1;
	localparam logic [2:0] KIND_ATTR     = 3'd2;
	localparam logic [2:0] KIND_REPEAT   = 3'd3;
	localparam logic [2:0] KIND_POSITION = 3'd4;
	localparam logic [2:0] KIND_FIELD    = 3'd5;
	localparam logic [2:0] KIND_CMD_END  = 3'd6;

	// Order and character codes.
	localparam logic [7:0] ORD_SOH    = 8'h01;
	localparam logic [7:0] ORD_RA     = 8'h02;
	localparam logic [7:0] ORD_ESC    = 8'h04;
	localparam logic [7:0] ORD_SBA    = 8'h11;
	localparam logic [7:0] ORD_SF     = 8'h1d;
	localparam logic [7:0] CHR_NUL    = 8'h00;
	localparam logic [7:0] CHR_SO     = 8'h0e;
	localparam logic [7:0] CHR_SI     = 8'h0f;
	localparam logic [7:0] CHR_DUP    = 8'h1c;
	localparam logic [7:0] CHR_FM     = 8'h1e;
	localparam logic [7:0] DATA_LO    = 8'h20;
	localparam logic [7:0] DATA_HI    = 8'hfe;
	localparam logic [7:0] TEXT_LIMIT = 8'h3f;
	localparam logic [7:0] HDR_MIN    = 8'h04;
	localparam logic [7:0] FFW_EXT    = 8'h40;
	localparam logic [7:0] FCW_MASK   = 8'he0;
	localparam logic [7:0] FCW_SHORT  = 8'h20;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  row;
		logic [7:0]  column;
		logic [7:0]  char_value;
		logic [15:0] field_length;
	} event_t;

	// All events caused by one input byte, in delivery order.
	typedef struct packed {
		logic   prim_valid;
		event_t prim;
		logic   close_valid;
		logic   end_valid;
	} bundle_t;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

	function automatic logic is_data_char(input logic [7:0] b);
		return (b == CHR_NUL) || (b == CHR_SO) || (b == CHR_SI) || (b == CHR_DUP) ||
			(b == CHR_FM) || ((b >= DATA_LO) && (b <= DATA_HI));
	endfunction

	function automatic logic is_attribute(input logic [7:0] b);
		return ((b >= 8'h20) && (b <= 8'h23)) || ((b >= 8'h27) && (b <= 8'h29)) ||
			(b == 8'h3a) || (b == 8'h3b);
	endfunction

endpackage

`default_nettype wire

### sv/dosp_front.sv
// ----------------------------------------------------------------------------
// dosp_front
// Accepts one byte per cycle while the queue is not full, tracks the order state and builds event bundles.
// ----------------------------------------------------------------------------
`default_nettype none

module dosp_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [7:0]       in_byte,
	input  wire logic             in_final,
	input  wire logic             queue_full,
	output logic                  in_ready,
	output logic                  push,
	output dosp_pkg::bundle_t     bundle
);
	import dosp_pkg::*;

	parse_state_t state_q, state_d;
	logic         text_q, text_d, text_mid;
	logic [7:0]   skip_q, skip_d, skip_dec;
	logic [7:0]   row_q, row_d;
	logic [7:0]   col_q, col_d;
	logic [7:0]   lenh_q, lenh_d;
	logic         accept;
	logic         end_cmd;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign end_cmd  = in_final || ((state_q == ST_MAIN) && (in_byte == ORD_ESC));
	assign skip_dec = (skip_q != 8'd0) ? (skip_q - 8'd1) : skip_q;

	always_comb begin : next_state
		state_d  = state_q;
		text_mid = text_q;
		skip_d   = skip_q;
		row_d    = row_q;
		col_d    = col_q;
		lenh_d   = lenh_q;
		unique case (state_q)
			ST_CC1: state_d = ST_CC2;
			ST_CC2: state_d = ST_MAIN;
			ST_MAIN: begin
				if (in_byte == ORD_ESC) begin
					state_d = ST_MAIN;
				end else if (is_data_char(in_byte)) begin
					if (in_byte > TEXT_LIMIT) begin
						text_mid = 1'b1;
					end
				end else begin
					text_mid = 1'b0;
					unique case (in_byte)
						ORD_SOH: state_d = ST_HDR_LEN;
						ORD_RA:  state_d = ST_RA_ROW;
						ORD_SBA: state_d = ST_SBA_ROW;
						ORD_SF:  state_d = ST_SF_FFW0;
						default: state_d = ST_MAIN;
					endcase
				end
			end
			ST_HDR_LEN: begin
				skip_d  = (in_byte > HDR_MIN) ? in_byte : HDR_MIN;
				state_d = ST_HDR_SKIP;
			end
			ST_HDR_SKIP: begin
				skip_d = skip_dec;
				if (skip_dec == 8'd0) begin
					state_d = ST_MAIN;
				end
			end
			ST_RA_ROW: begin
				row_d   = in_byte;
				state_d = ST_RA_COL;
			end
			ST_RA_COL: begin
				col_d   = in_byte;
				state_d = ST_RA_CHAR;
			end
			ST_RA_CHAR: state_d = ST_MAIN;
			ST_SBA_ROW: begin
				row_d   = in_byte;
				state_d = ST_SBA_COL;
			end
			ST_SBA_COL: state_d = ST_MAIN;
			ST_SF_FFW0: state_d = ((in_byte & FFW_EXT) != 8'd0) ? ST_SF_FFW1 : ST_SF_LEN0;
			ST_SF_FFW1: state_d = ST_SF_FCW0;
			ST_SF_FCW0: state_d = ((in_byte & FCW_MASK) == FCW_SHORT) ? ST_SF_LEN0 : ST_SF_FCW1;
			ST_SF_FCW1: state_d = ST_SF_LEN0;
			ST_SF_LEN0: begin
				lenh_d  = in_byte;
				state_d = ST_SF_LEN1;
			end
			ST_SF_LEN1: state_d = ST_MAIN;
			default:    state_d = ST_MAIN;
		endcase
		text_d = text_mid;
		if (end_cmd) begin
			state_d = ST_CC1;
			text_d  = 1'b0;
			skip_d  = 8'd0;
			row_d   = 8'd0;
			col_d   = 8'd0;
			lenh_d  = 8'd0;
		end
	end

	always_comb begin : outputs
		bundle = '0;
		unique case (state_q)
			ST_MAIN: begin
				if (in_byte != ORD_ESC) begin
					if (is_data_char(in_byte)) begin
						if (in_byte > TEXT_LIMIT) begin
							bundle.prim_valid      = 1'b1;
							bundle.prim.kind       = KIND_TEXT;
							bundle.prim.char_value = in_byte;
						end else if (is_attribute(in_byte)) begin
							bundle.prim_valid      = 1'b1;
							bundle.prim.kind       = KIND_ATTR;
							bundle.prim.char_value = in_byte;
						end
					end else if (text_q) begin
						bundle.prim_valid = 1'b1;
						bundle.prim.kind  = KIND_RUN_END;
					end
				end
			end
			ST_RA_CHAR: begin
				bundle.prim_valid      = 1'b1;
				bundle.prim.kind       = KIND_REPEAT;
				bundle.prim.row        = row_q;
				bundle.prim.column     = col_q;
				bundle.prim.char_value = in_byte;
			end
			ST_SBA_COL: begin
				bundle.prim_valid  = 1'b1;
				bundle.prim.kind   = KIND_POSITION;
				bundle.prim.row    = row_q;
				bundle.prim.column = in_byte;
			end
			ST_SF_LEN1: begin
				bundle.prim_valid        = 1'b1;
				bundle.prim.kind         = KIND_FIELD;
				bundle.prim.field_length = {lenh_q, in_byte};
			end
			default: bundle.prim_valid = 1'b0;
		endcase
		bundle.close_valid = end_cmd && text_mid;
		bundle.end_valid   = end_cmd;
		push = accept && (bundle.prim_valid || bundle.end_valid);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CC1;
			text_q  <= 1'b0;
			skip_q  <= 8'd0;
			row_q   <= 8'd0;
			col_q   <= 8'd0;
			lenh_q  <= 8'd0;
		end else if (accept) begin
			state_q <= state_d;
			text_q  <= text_d;
			skip_q  <= skip_d;
			row_q   <= row_d;
			col_q   <= col_d;
			lenh_q  <= lenh_d;
		end
	end

endmodule

`default_nettype wire

### sv/dosp_fifo.sv
// ----------------------------------------------------------------------------
// dosp_fifo
// Short queue of event bundles between the parser and the event serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module dosp_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire dosp_pkg::bundle_t wr_data,
	input  wire logic              pop,
	output dosp_pkg::bundle_t      rd_data,
	output logic                   full,
	output logic                   empty
);
	import dosp_pkg::*;

	bundle_t               mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	assign full    = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`include "assert_macros.svh"

	`DOSP_ASSERT(a_count_range, count_q <= FIFO_CNT_W'(FIFO_DEPTH), "queue count out of range")
	`DOSP_ASSERT_IMPLIES(a_no_overflow, push, !full || pop, "push into a full queue")
	`DOSP_ASSERT_IMPLIES(a_no_underflow, pop, !empty, "pop from an empty queue")
	`DOSP_ASSERT_NEXT(a_count_inc, push && !pop, count_q == $past(count_q) + 1'b1, "count lost a push")

endmodule

`default_nettype wire

### sv/dosp_back.sv
// ----------------------------------------------------------------------------
// dosp_back
// Delivers the events of the head bundle one per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module dosp_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dosp_pkg::bundle_t head,
	input  wire logic              queue_empty,
	input  wire logic              out_ready,
	output logic                   pop,
	output logic                   out_valid,
	output dosp_pkg::event_t       out_event,
	output logic                   out_last
);
	import dosp_pkg::*;

	logic prim_done_q;
	logic close_done_q;
	logic take_prim;
	logic take_close;
	logic handshake;

	assign out_valid  = !queue_empty;
	assign take_prim  = head.prim_valid && !prim_done_q;
	assign take_close = !take_prim && head.close_valid && !close_done_q;
	assign handshake  = out_valid && out_ready;
	assign pop        = handshake && out_last;

	always_comb begin
		out_event = '0;
		if (take_prim) begin
			out_event = head.prim;
			out_last  = !head.close_valid && !head.end_valid;
		end else if (take_close) begin
			out_event.kind = KIND_RUN_END;
			out_last       = !head.end_valid;
		end else begin
			out_event.kind = KIND_CMD_END;
			out_last       = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prim_done_q  <= 1'b0;
			close_done_q <= 1'b0;
		end else if (pop) begin
			prim_done_q  <= 1'b0;
			close_done_q <= 1'b0;
		end else if (handshake) begin
			if (take_prim) begin
				prim_done_q <= 1'b1;
			end else if (take_close) begin
				close_done_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### sv/display_order_stream_parser.sv
// ----------------------------------------------------------------------------
// display_order_stream_parser - write-to-display order stream parser
// Flow: an accepted byte's events are written to the queue as one bundle, then shown on the master side.
// Throughput: one byte per cycle while the queue is not full; a byte with k events takes k output transactions.
// Reset: arst_n clears the parser to await the first control byte and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module display_order_stream_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Slave side: one byte of the data stream per transaction.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tlast,   // final_byte
	// Master side: one parsed event per transaction.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // [7:0] row, [15:8] column, [23:16] char_value,
	                                    // [39:24] field_length
	output logic [2:0]       m_tuser,   // [2:0] event_kind
	output logic             m_tlast    // last event caused by the input byte
);
	import dosp_pkg::*;

	bundle_t fr_bundle;
	bundle_t head;
	event_t  ev;
	logic    fr_push;
	logic    q_full;
	logic    q_empty;
	logic    bk_pop;

	// The front decodes every accepted byte in the cycle it arrives and writes
	// all events it causes (at most three) into the queue as one bundle. Bytes
	// that cause nothing, such as control characters and operand bytes, are
	// consumed without touching the queue.
	dosp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_byte    (s_tdata),
		.in_final   (s_tlast),
		.queue_full (q_full),
		.in_ready   (s_tready),
		.push       (fr_push),
		.bundle     (fr_bundle)
	);

	// The queue lets the front keep taking bytes while the back waits on a
	// stalled consumer or is still working through a multi-event bundle.
	dosp_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (fr_push),
		.wr_data (fr_bundle),
		.pop     (bk_pop),
		.rd_data (head),
		.full    (q_full),
		.empty   (q_empty)
	);

	// The back walks the head bundle in order: the primary event, then the
	// closing of open text, then the command end, marking the final one.
	dosp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.queue_empty (q_empty),
		.out_ready   (m_tready),
		.pop         (bk_pop),
		.out_valid   (m_tvalid),
		.out_event   (ev),
		.out_last    (m_tlast)
	);

	assign m_tdata = {ev.field_length, ev.char_value, ev.column, ev.row};
	assign m_tuser = ev.kind;

endmodule

`default_nettype wire

### bench/tb_display_order_stream_parser.sv
// ----------------------------------------------------------------------------
// tb_display_order_stream_parser - testbench of the display order stream parser
// Sends write-to-display byte streams and checks every parsed event against
// a behavioral predictor of the parser. Directed streams come first, then
// random commands, with random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_display_order_stream_parser;
	timeunit 1ns;
	timeprecision 1ps;

	import dosp_pkg::*;

	// Attribute bytes come in three groups; the first starts at DATA_LO.
	localparam logic [7:0] ATTR_SET1_HI = 8'h23;
	localparam logic [7:0] ATTR_SET2_LO = 8'h27;
	localparam logic [7:0] ATTR_SET2_HI = 8'h29;
	localparam logic [7:0] ATTR_SET3_LO = 8'h3a;
	localparam logic [7:0] ATTR_SET3_HI = 8'h3b;

	// Stream bytes to send in all, skipped header bytes included.
	localparam int BYTE_TARGET = 160;
	// Cycles without progress on either side before the run is abandoned.
	localparam int IDLE_LIMIT  = 1000;

	// Receiver stall patterns.
	typedef enum logic [1:0] {
		RX_FREE,
		RX_LIGHT,
		RX_HEAVY,
		RX_PERIODIC
	} rx_mode_t;

	// One parsed event as it is expected on the master side.
	typedef struct {
		logic [2:0]  kind;
		logic [7:0]  row;
		logic [7:0]  column;
		logic [7:0]  char_value;
		logic [15:0] field_length;
		logic        last;
	} parsed_event_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;   // [7:0] data_byte
	logic        s_tlast  = 1'b0;    // final_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;            // [7:0] row, [15:8] column, [23:16] char_value,
	                                 // [39:24] field_length
	logic [2:0]  m_tuser;            // [2:0] event_kind
	logic        m_tlast;

	// Expected events, oldest first.
	parsed_event_t pending_events[$];

	// Predictor copy of the parser state.
	parse_state_t parser_state = ST_CC1;
	logic         text_is_open = 1'b0;
	logic [7:0]   header_left  = 8'h00;
	logic [7:0]   held_row     = 8'h00;
	logic [7:0]   held_column  = 8'h00;
	logic [7:0]   held_len_hi  = 8'h00;

	int errors          = 0;
	int bytes_sent      = 0;
	int skipped_bytes   = 0;
	int commands_sent   = 0;
	int events_checked  = 0;
	int burst_left      = 0;
	rx_mode_t rx_mode   = RX_FREE;
	int rx_phase_left   = 0;

	display_order_stream_parser u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial forever #1 clk = ~clk;

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	function automatic logic byte_is_data(input logic [7:0] b);
		return b inside {CHR_NUL, CHR_SO, CHR_SI, CHR_DUP, CHR_FM, [DATA_LO:DATA_HI]};
	endfunction

	function automatic logic byte_is_attribute(input logic [7:0] b);
		return b inside {[DATA_LO:ATTR_SET1_HI], [ATTR_SET2_LO:ATTR_SET2_HI],
			[ATTR_SET3_LO:ATTR_SET3_HI]};
	endfunction

	// Works out the events that one accepted stream byte causes and queues them.
	function automatic void predict_events(input logic [7:0] b, input logic fin);
		parsed_event_t batch[3];
		int            count;
		logic          closes_command;
		count = 0;
		closes_command = fin;
		foreach (batch[i]) batch[i] = '{KIND_TEXT, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0};

		case (parser_state)
			ST_CC1: parser_state = ST_CC2;
			ST_CC2: parser_state = ST_MAIN;
			ST_MAIN: begin
				if (b == ORD_ESC) begin
					closes_command = 1'b1;
				end else if (byte_is_data(b)) begin
					if (b > TEXT_LIMIT) begin
						text_is_open = 1'b1;
						batch[count].kind = KIND_TEXT;
						batch[count].char_value = b;
						count++;
					end else if (byte_is_attribute(b)) begin
						batch[count].kind = KIND_ATTR;
						batch[count].char_value = b;
						count++;
					end
				end else begin
					// Any order closes a text run, even one that is ignored.
					if (text_is_open) begin
						text_is_open = 1'b0;
						batch[count].kind = KIND_RUN_END;
						count++;
					end
					case (b)
						ORD_SOH: parser_state = ST_HDR_LEN;
						ORD_RA:  parser_state = ST_RA_ROW;
						ORD_SBA: parser_state = ST_SBA_ROW;
						ORD_SF:  parser_state = ST_SF_FFW0;
						default: ;
					endcase
				end
			end
			ST_HDR_LEN: begin
				header_left = (b > HDR_MIN) ? b : HDR_MIN;
				parser_state = ST_HDR_SKIP;
			end
			ST_HDR_SKIP: begin
				if (header_left != 8'h00) header_left--;
				if (header_left == 8'h00) parser_state = ST_MAIN;
			end
			ST_RA_ROW: begin
				held_row = b;
				parser_state = ST_RA_COL;
			end
			ST_RA_COL: begin
				held_column = b;
				parser_state = ST_RA_CHAR;
			end
			ST_RA_CHAR: begin
				batch[count].kind = KIND_REPEAT;
				batch[count].row = held_row;
				batch[count].column = held_column;
				batch[count].char_value = b;
				count++;
				parser_state = ST_MAIN;
			end
			ST_SBA_ROW: begin
				held_row = b;
				parser_state = ST_SBA_COL;
			end
			ST_SBA_COL: begin
				batch[count].kind = KIND_POSITION;
				batch[count].row = held_row;
				batch[count].column = b;
				count++;
				parser_state = ST_MAIN;
			end
			ST_SF_FFW0: parser_state = ((b & FFW_EXT) != 8'h00) ? ST_SF_FFW1 : ST_SF_LEN0;
			ST_SF_FFW1: parser_state = ST_SF_FCW0;
			ST_SF_FCW0: parser_state = ((b & FCW_MASK) == FCW_SHORT) ? ST_SF_LEN0 : ST_SF_FCW1;
			ST_SF_FCW1: parser_state = ST_SF_LEN0;
			ST_SF_LEN0: begin
				held_len_hi = b;
				parser_state = ST_SF_LEN1;
			end
			ST_SF_LEN1: begin
				batch[count].kind = KIND_FIELD;
				batch[count].field_length = {held_len_hi, b};
				count++;
				parser_state = ST_MAIN;
			end
			default: parser_state = ST_MAIN;
		endcase

		// ESC or the final byte drops any partial order, closes open text and
		// ends the command; the parser then waits for the next control bytes.
		if (closes_command) begin
			if (text_is_open) begin
				batch[count].kind = KIND_RUN_END;
				count++;
			end
			batch[count].kind = KIND_CMD_END;
			count++;
			parser_state = ST_CC1;
			text_is_open = 1'b0;
			header_left  = 8'h00;
			held_row     = 8'h00;
			held_column  = 8'h00;
			held_len_hi  = 8'h00;
		end

		for (int i = 0; i < count; i++) begin
			batch[i].last = (i == count - 1);
			pending_events.push_back(batch[i]);
		end
	endfunction

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------

	function automatic void compare_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endfunction

	function automatic void check_event();
		parsed_event_t want;
		if (pending_events.size() == 0) begin
			$error("event kind %0d arrived with no event expected", m_tuser);
			errors++;
		end else begin
			want = pending_events.pop_front();
			compare_field("event_kind", want.kind, m_tuser);
			compare_field("row", want.row, m_tdata[7:0]);
			compare_field("column", want.column, m_tdata[15:8]);
			compare_field("char_value", want.char_value, m_tdata[23:16]);
			compare_field("field_length", want.field_length, m_tdata[39:24]);
			compare_field("last", want.last, m_tlast);
			events_checked++;
		end
	endfunction

	// Both sides are sampled at the rising edge. An accepted byte is predicted
	// before any event of the same edge is checked, so a pending queue can
	// never look empty to an event that the byte itself caused.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) predict_events(s_tdata, s_tlast);
			if (m_tvalid && m_tready) check_event();
		end
	end

	// The receiver switches between stall patterns at random intervals, so
	// that back pressure lands on every phase of an order, including runs of
	// free-flowing cycles.
	always @(negedge clk) begin
		if (rx_phase_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_phase_left = $urandom_range(16, 80);
		end else begin
			rx_phase_left--;
		end
		case (rx_mode)
			RX_FREE:     m_tready <= 1'b1;
			RX_LIGHT:    m_tready <= ($urandom_range(0, 3) != 0);
			RX_HEAVY:    m_tready <= ($urandom_range(0, 3) == 0);
			RX_PERIODIC: m_tready <= (rx_phase_left % 5 < 2);
			default:     m_tready <= 1'b1;
		endcase
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------

	// Sends one stream byte. Called at a falling edge and returns at the
	// falling edge after the transaction. A new burst may open with a gap in
	// which tvalid is low.
	task automatic send_byte(input logic [7:0] value, input logic fin);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tlast  <= fin;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		bytes_sent++;
	endtask

	// Sends a whole command; the final-byte flag goes on its last byte if asked.
	task automatic send_command(input logic [7:0] bytes[$], input logic fin_on_last);
		foreach (bytes[i]) send_byte(bytes[i], fin_on_last && (i == bytes.size() - 1));
		commands_sent++;
	endtask

	// Holds the sender off until every expected event has been delivered.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_events.size() != 0) @(negedge clk);
	endtask

	// Text runs, attributes, dropped low characters, an ignored order closing
	// a run, and ESC closing the open run at the end of the command.
	task automatic test_text_runs();
		send_command('{8'hf5, 8'hc3, 8'h41, 8'hff, DATA_LO, TEXT_LIMIT, 8'h5a, ORD_ESC}, 1'b0);
	endtask

	// A short header that still skips four bytes, ESC and orders among them,
	// repeat and position at the byte extremes, a field with both extension
	// words and the largest length, then a final text byte that gives the
	// most events one byte can cause.
	task automatic test_orders();
		send_command('{8'h00, 8'hff, ORD_SOH, 8'h00, ORD_ESC, ORD_SF, ORD_SBA, ORD_SOH,
			ORD_RA, 8'h00, 8'hff, ORD_ESC, ORD_SBA, 8'hff, 8'h00,
			ORD_SF, FFW_EXT, 8'h00, FCW_MASK, 8'h00, 8'hff, 8'hff, 8'h80}, 1'b1);
	endtask

	// Mostly well-formed commands with random content; some elements are raw
	// noise, and commands end by ESC, by the final flag, by a stray last byte,
	// or are cut off anywhere, including inside control bytes and operands.
	task automatic test_random_commands();
		logic [7:0] cmd[$];
		logic [7:0] b;
		logic [7:0] low_codes[5];
		logic       fin_on_last;
		logic       long_header_done;
		int         run_len;
		int         cut;
		low_codes = '{CHR_NUL, CHR_SO, CHR_SI, CHR_DUP, CHR_FM};
		long_header_done = 1'b0;

		while (bytes_sent < BYTE_TARGET) begin
			cmd = {};
			cmd.push_back(8'($urandom));
			cmd.push_back(8'($urandom));
			repeat ($urandom_range(1, 8)) begin
				case ($urandom_range(0, 9))
					0, 1: begin
						run_len = $urandom_range(1, 6);
						repeat (run_len) cmd.push_back(8'($urandom_range(TEXT_LIMIT + 1, DATA_HI)));
					end
					2: cmd.push_back(8'($urandom_range(DATA_LO, TEXT_LIMIT)));
					3: cmd.push_back(low_codes[$urandom_range(0, 4)]);
					4: begin
						// Header: mostly short, at times medium, once a long one.
						if (!long_header_done && bytes_sent > 100) begin
							b = 8'h20;
							long_header_done = 1'b1;
						end else if ($urandom_range(0, 7) == 0) begin
							b = 8'($urandom_range(9, 16));
						end else begin
							b = 8'($urandom_range(0, 8));
						end
						cmd.push_back(ORD_SOH);
						cmd.push_back(b);
						run_len = int'((b > HDR_MIN) ? b : HDR_MIN);
						repeat (run_len) cmd.push_back(8'($urandom));
						skipped_bytes += run_len;
					end
					5: begin
						cmd.push_back(ORD_RA);
						repeat (3) cmd.push_back(8'($urandom));
					end
					6: begin
						cmd.push_back(ORD_SBA);
						repeat (2) cmd.push_back(8'($urandom));
					end
					7: begin
						cmd.push_back(ORD_SF);
						b = 8'($urandom);
						cmd.push_back(b);
						if ((b & FFW_EXT) != 8'h00) begin
							cmd.push_back(8'($urandom));
							b = $urandom_range(0, 1) ? 8'($urandom_range(FCW_SHORT, FCW_SHORT + 8'h1f))
								: 8'($urandom);
							cmd.push_back(b);
							if ((b & FCW_MASK) != FCW_SHORT) cmd.push_back(8'($urandom));
						end
						repeat (2) cmd.push_back(8'($urandom));
					end
					8: begin
						// An order that the parser ignores.
						if ($urandom_range(0, 3) == 0) begin
							b = 8'hff;
						end else begin
							do b = 8'($urandom_range(0, 31));
							while (byte_is_data(b) || b inside {ORD_ESC, ORD_SOH, ORD_RA, ORD_SBA, ORD_SF});
						end
						cmd.push_back(b);
					end
					default: cmd.push_back(8'($urandom));
				endcase
			end

			case ($urandom_range(0, 3))
				0: begin
					cmd.push_back(ORD_ESC);
					fin_on_last = ($urandom_range(0, 3) == 0);
				end
				1: fin_on_last = 1'b1;
				2: begin
					cut = $urandom_range(1, cmd.size());
					while (cmd.size() > cut) void'(cmd.pop_back());
					fin_on_last = 1'b1;
				end
				default: begin
					cmd.push_back(8'($urandom));
					fin_on_last = 1'b1;
				end
			endcase
			send_command(cmd, fin_on_last);
		end
	endtask

	// ------------------------------------------------------------------------
	// Run control
	// ------------------------------------------------------------------------

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_text_runs();
		test_orders();
		// The sender stops here until the directed events have all come back.
		wait_drained();
		test_random_commands();
		wait_drained();
		// The parser's events come out of its queue; waiting on after the drain
		// would show any event that it should not have produced.
		repeat (8) @(posedge clk);

		$display("Sent %0d commands in %0d stream bytes (%0d of them skipped header bytes);",
			commands_sent, bytes_sent, skipped_bytes);
		$display("checked %0d parsed events under random bursts and receiver stalls.",
			events_checked);
		if (errors == 0 && pending_events.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Watchdog: ends the run if no byte is taken and no expected event is
	// delivered for too long; events that nobody expects do not count.
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		@(posedge arst_n);
		while (quiet_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) ||
				(m_tvalid && m_tready && pending_events.size() != 0)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$error("no transaction for %0d cycles, %0d events still expected", IDLE_LIMIT,
			pending_events.size());
		$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire

### display_order_stream_parser.f
+incdir+sv
sv/dosp_pkg.sv
sv/dosp_front.sv
sv/dosp_fifo.sv
sv/dosp_back.sv
sv/display_order_stream_parser.sv
bench/tb_display_order_stream_parser.sv
